@@ rtl/irb_pkg.sv @@
// ----------------------------------------------------------------------------
// irb_pkg
// Shared types and constants for the in-order read return buffer.
// ----------------------------------------------------------------------------
package irb_pkg;

   localparam int ORDER_DEPTH_DEF = 16;
   localparam int MERGE_DEPTH_DEF = 16;
   localparam int TAG_WIDTH_DEF   = 32;

   localparam int COUNT_W = 32;
   localparam int LIMIT_W = 5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   // request codes carried in tuser
   localparam logic [1:0] FUNC_ISSUE = 2'd0;
   localparam logic [1:0] FUNC_COMPL = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;

   // request kinds of an issue
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_HEAD,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic rd_head;
   } oq_cmd_type;

   typedef struct packed {
      logic insert;
      logic rel;
   } ms_cmd_type;

   typedef struct packed {
      logic full;
      logic found;
      logic busy;
   } ms_stat_type;

   typedef struct packed {
      logic accepted;
      logic rel_valid;
      logic dropped;
   } res_flags_type;

endpackage

@@ rtl/irb_order_queue.sv @@
// ----------------------------------------------------------------------------
// irb_order_queue
// Circular queue of issued read tags in a synchronous memory, head read
// registered in the cycle after it is requested.
// ----------------------------------------------------------------------------
module irb_order_queue #(
   parameter int ORDER_DEPTH = irb_pkg::ORDER_DEPTH_DEF,
   parameter int TAG_WIDTH   = irb_pkg::TAG_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  irb_pkg::oq_cmd_type                oq_cmd,
   input  logic [TAG_WIDTH-1:0]               push_tag,
   output logic [$clog2(ORDER_DEPTH+1)-1:0]   count,
   output logic [TAG_WIDTH-1:0]               head_tag
);
   import irb_pkg::*;

   localparam int PW = $clog2(ORDER_DEPTH);
   localparam int CW = $clog2(ORDER_DEPTH + 1);

   logic [TAG_WIDTH-1:0] mem [ORDER_DEPTH];
   logic [PW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [TAG_WIDTH-1:0] head_tag_ff;
   logic [PW:0]          tail_sum;
   logic [PW-1:0]        tail;

   always_comb begin
      tail_sum = {1'b0, head_ff} + (PW+1)'(count_ff);
      if (tail_sum >= (PW+1)'(ORDER_DEPTH)) begin
         tail = PW'(tail_sum - (PW+1)'(ORDER_DEPTH));
      end else begin
         tail = PW'(tail_sum);
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (oq_cmd.push) begin
         count_in = count_ff + CW'(1);
      end
      if (oq_cmd.pop) begin
         count_in = count_ff - CW'(1);
         if (head_ff == PW'(ORDER_DEPTH - 1)) begin
            head_in = '0;
         end else begin
            head_in = head_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (oq_cmd.push) begin
         mem[tail] <= push_tag;
      end
      if (oq_cmd.rd_head) begin
         head_tag_ff <= mem[head_ff];
      end
   end

   assign count    = count_ff;
   assign head_tag = head_tag_ff;

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      oq_cmd.push |-> count_ff < CW'(ORDER_DEPTH))
      else $error("order queue push while full");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      oq_cmd.pop |-> count_ff != '0)
      else $error("order queue pop while empty");

   a_pop_after_read: assert property (@(posedge clock) disable iff (reset)
      oq_cmd.pop |-> $past(oq_cmd.rd_head) && !oq_cmd.push)
      else $error("order queue pop without a fresh head read");

endmodule

@@ rtl/irb_merge_store.sv @@
// ----------------------------------------------------------------------------
// irb_merge_store
// Completion tags in a synchronous memory with per-slot valid bits, a cached
// smallest pending tag and a rescan sweep after each release.
// ----------------------------------------------------------------------------
module irb_merge_store #(
   parameter int MERGE_DEPTH = irb_pkg::MERGE_DEPTH_DEF,
   parameter int TAG_WIDTH   = irb_pkg::TAG_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  irb_pkg::ms_cmd_type   ms_cmd,
   input  logic [TAG_WIDTH-1:0]  ins_tag,
   output irb_pkg::ms_stat_type  ms_stat,
   output logic [TAG_WIDTH-1:0]  best_tag
);
   import irb_pkg::*;

   localparam int SW = $clog2(MERGE_DEPTH);

   logic [TAG_WIDTH-1:0]   mem [MERGE_DEPTH];
   logic [MERGE_DEPTH-1:0] valid_ff, valid_in;
   logic                   found_ff, found_in;
   logic [TAG_WIDTH-1:0]   best_tag_ff, best_tag_in;
   logic [SW-1:0]          best_slot_ff, best_slot_in;
   logic                   scan_active_ff, scan_active_in;
   logic [SW-1:0]          scan_addr_ff, scan_addr_in;
   logic                   scan_pend_ff;
   logic [SW-1:0]          scan_slot_ff;
   logic [TAG_WIDTH-1:0]   rd_tag_ff;
   logic [SW-1:0]          free_slot;
   logic                   free_found;

   // lowest free slot
   always_comb begin
      free_slot  = '0;
      free_found = 1'b0;
      for (int i = 0; i < MERGE_DEPTH; i++) begin
         if (!valid_ff[i] && !free_found) begin
            free_slot  = SW'(i);
            free_found = 1'b1;
         end
      end
   end

   always_comb begin
      valid_in       = valid_ff;
      found_in       = found_ff;
      best_tag_in    = best_tag_ff;
      best_slot_in   = best_slot_ff;
      scan_active_in = scan_active_ff;
      scan_addr_in   = scan_addr_ff;
      if (ms_cmd.insert) begin
         valid_in[free_slot] = 1'b1;
         if (!found_ff || ins_tag < best_tag_ff ||
             (ins_tag == best_tag_ff && free_slot < best_slot_ff)) begin
            found_in     = 1'b1;
            best_tag_in  = ins_tag;
            best_slot_in = free_slot;
         end
      end
      if (ms_cmd.rel) begin
         // drop the released slot and sweep the store for the new minimum
         valid_in[best_slot_ff] = 1'b0;
         found_in               = 1'b0;
         scan_active_in         = 1'b1;
         scan_addr_in           = '0;
      end
      if (scan_active_ff) begin
         scan_addr_in = scan_addr_ff + SW'(1);
         if (scan_addr_ff == SW'(MERGE_DEPTH - 1)) begin
            scan_active_in = 1'b0;
         end
      end
      // strict compare keeps the lowest slot on equal tags
      if (scan_pend_ff && valid_ff[scan_slot_ff] &&
          (!found_ff || rd_tag_ff < best_tag_ff)) begin
         found_in     = 1'b1;
         best_tag_in  = rd_tag_ff;
         best_slot_in = scan_slot_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         found_ff       <= 1'b0;
         scan_active_ff <= 1'b0;
         scan_pend_ff   <= 1'b0;
         scan_addr_ff   <= '0;
      end else begin
         valid_ff       <= valid_in;
         found_ff       <= found_in;
         scan_active_ff <= scan_active_in;
         scan_pend_ff   <= scan_active_ff;
         scan_addr_ff   <= scan_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      best_tag_ff  <= best_tag_in;
      best_slot_ff <= best_slot_in;
      scan_slot_ff <= scan_addr_ff;
   end

   always_ff @(posedge clock) begin
      if (ms_cmd.insert) begin
         mem[free_slot] <= ins_tag;
      end
      if (scan_active_ff) begin
         rd_tag_ff <= mem[scan_addr_ff];
      end
   end

   assign ms_stat.full  = !free_found;
   assign ms_stat.found = found_ff;
   assign ms_stat.busy  = scan_active_ff | scan_pend_ff;
   assign best_tag      = best_tag_ff;

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      ms_cmd.insert |-> free_found && !ms_stat.busy)
      else $error("merge store insert while full or sweeping");

   a_release_valid: assert property (@(posedge clock) disable iff (reset)
      ms_cmd.rel |-> found_ff && valid_ff[best_slot_ff] && !ms_cmd.insert)
      else $error("merge store release of an empty slot");

   a_release_sweep: assert property (@(posedge clock) disable iff (reset)
      ms_cmd.rel |=> scan_active_ff && !found_ff)
      else $error("merge store release did not start a sweep");

endmodule

@@ rtl/in_order_read_return_buffer_unit.sv @@
// ----------------------------------------------------------------------------
// in_order_read_return_buffer_unit
// Front end that refuses issues past the read limit, merges completions and
// hands reads back in issue order.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: tuser holds the code (issue, completion,
//   tick); tdata holds kind, tag and the channel-accepted flag. rsp_*
//   returns exactly one result per request: the issue verdict, the released
//   read, the drop flag and the three request counters after the request.
//   csr_wr_en writes the read queue limit (reset 16, clamped to the order
//   queue depth); the user must use it only while the block is idle, as the
//   block itself does not enforce this. Requests are handled one at a time.
//   A tick that finds a pending tag and a queued read also reads the order
//   queue head; a releasing tick then waits for the sweep of the merge store
//   memory at one slot a cycle for the new minimum. A finished result sits
//   in the output register; the next request is taken while it waits, and
//   is held in its last step until rsp_tready frees the register. Reset
//   clears the queues, valid bits and counters and sets the limit to 16;
//   memory contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module in_order_read_return_buffer_unit #(
   parameter int ORDER_DEPTH = irb_pkg::ORDER_DEPTH_DEF,
   parameter int MERGE_DEPTH = irb_pkg::MERGE_DEPTH_DEF,
   parameter int TAG_WIDTH   = irb_pkg::TAG_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // req_kind, tag, channel_accepted
   input  logic [((TAG_WIDTH + 3 + 7) / 8) * 8 - 1:0] req_tdata,
   // func
   input  logic [1:0]                               req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // accepted, released_valid, released_tag, completion_dropped,
   // read_total, write_total, other_total
   output logic [((TAG_WIDTH + 99 + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic                                     csr_wr_en,
   input  logic [irb_pkg::LIMIT_W-1:0]              csr_wr_data
);
   import irb_pkg::*;

   localparam int REQ_W = ((TAG_WIDTH + 3 + 7) / 8) * 8;
   localparam int RSP_W = ((TAG_WIDTH + 99 + 7) / 8) * 8;
   localparam int CW    = $clog2(ORDER_DEPTH + 1);
   localparam int LW    = (CW > LIMIT_W) ? CW : LIMIT_W;

   state_type            state_ff, state_in;
   logic [1:0]           func_ff, func_in;
   logic [1:0]           kind_ff, kind_in;
   logic [TAG_WIDTH-1:0] tag_ff, tag_in;
   logic                 chan_ff, chan_in;
   res_flags_type        res_ff, res_in;
   logic [TAG_WIDTH-1:0] rel_tag_ff, rel_tag_in;
   logic [COUNT_W-1:0]   rd_cnt_ff, rd_cnt_in;
   logic [COUNT_W-1:0]   wr_cnt_ff, wr_cnt_in;
   logic [COUNT_W-1:0]   ot_cnt_ff, ot_cnt_in;
   logic [LIMIT_W-1:0]   limit_ff;
   logic [LW-1:0]        limit_ext, eff_limit;
   logic                 rsp_tvalid_ff;
   logic [RSP_W-1:0]     rsp_tdata_ff;
   logic                 finish, load_out, out_free;

   oq_cmd_type           oq_cmd;
   logic [CW-1:0]        oq_count;
   logic [TAG_WIDTH-1:0] oq_head_tag;
   ms_cmd_type           ms_cmd;
   ms_stat_type          ms_stat;
   logic [TAG_WIDTH-1:0] ms_best_tag;

   irb_order_queue #(
      .ORDER_DEPTH (ORDER_DEPTH),
      .TAG_WIDTH   (TAG_WIDTH)
   ) u_order (
      .clock    (clock),
      .reset    (reset),
      .oq_cmd   (oq_cmd),
      .push_tag (tag_ff),
      .count    (oq_count),
      .head_tag (oq_head_tag)
   );

   irb_merge_store #(
      .MERGE_DEPTH (MERGE_DEPTH),
      .TAG_WIDTH   (TAG_WIDTH)
   ) u_merge (
      .clock    (clock),
      .reset    (reset),
      .ms_cmd   (ms_cmd),
      .ins_tag  (tag_ff),
      .ms_stat  (ms_stat),
      .best_tag (ms_best_tag)
   );

   // clamp the limit to the queue depth
   always_comb begin
      limit_ext = LW'(limit_ff);
      if (limit_ext > LW'(ORDER_DEPTH)) begin
         eff_limit = LW'(ORDER_DEPTH);
      end else begin
         eff_limit = limit_ext;
      end
   end

   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      kind_in    = kind_ff;
      tag_in     = tag_ff;
      chan_in    = chan_ff;
      res_in     = res_ff;
      rel_tag_in = rel_tag_ff;
      rd_cnt_in  = rd_cnt_ff;
      wr_cnt_in  = wr_cnt_ff;
      ot_cnt_in  = ot_cnt_ff;
      oq_cmd     = '0;
      ms_cmd     = '0;
      req_tready = 1'b0;
      finish     = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               func_in    = req_tuser;
               kind_in    = req_tdata[1:0];
               tag_in     = req_tdata[2 +: TAG_WIDTH];
               chan_in    = req_tdata[2 + TAG_WIDTH];
               res_in     = '0;
               rel_tag_in = '0;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (func_ff)
               FUNC_ISSUE: begin
                  if (LW'(oq_count) < eff_limit && chan_ff) begin
                     res_in.accepted = 1'b1;
                     case (kind_ff)
                        KIND_READ: begin
                           rd_cnt_in   = rd_cnt_ff + COUNT_W'(1);
                           oq_cmd.push = 1'b1;
                        end
                        KIND_WRITE: begin
                           wr_cnt_in = wr_cnt_ff + COUNT_W'(1);
                        end
                        default: begin
                           ot_cnt_in = ot_cnt_ff + COUNT_W'(1);
                        end
                     endcase
                  end
                  finish = 1'b1;
               end
               FUNC_COMPL: begin
                  if (ms_stat.full) begin
                     res_in.dropped = 1'b1;
                  end else begin
                     ms_cmd.insert = 1'b1;
                  end
                  finish = 1'b1;
               end
               FUNC_TICK: begin
                  if (ms_stat.found && oq_count != '0) begin
                     oq_cmd.rd_head = 1'b1;
                     state_in       = ST_HEAD;
                  end else begin
                     finish = 1'b1;
                  end
               end
               default: begin
                  finish = 1'b1;
               end
            endcase
         end
         ST_HEAD: begin
            if (ms_best_tag == oq_head_tag) begin
               ms_cmd.rel       = 1'b1;
               oq_cmd.pop       = 1'b1;
               res_in.rel_valid = 1'b1;
               rel_tag_in       = oq_head_tag;
               state_in         = ST_SCAN;
            end else begin
               finish = 1'b1;
            end
         end
         ST_SCAN: begin
            // hold until the sweep has settled the new minimum
            if (!ms_stat.busy) begin
               finish = 1'b1;
            end
         end
         ST_DONE: begin
            finish = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (finish) begin
         if (out_free) begin
            load_out = 1'b1;
            state_in = ST_IDLE;
         end else begin
            state_in = ST_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rd_cnt_ff     <= '0;
         wr_cnt_ff     <= '0;
         ot_cnt_ff     <= '0;
         limit_ff      <= LIMIT_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_cnt_ff <= rd_cnt_in;
         wr_cnt_ff <= wr_cnt_in;
         ot_cnt_ff <= ot_cnt_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         if (load_out) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff    <= func_in;
      kind_ff    <= kind_in;
      tag_ff     <= tag_in;
      chan_ff    <= chan_in;
      res_ff     <= res_in;
      rel_tag_ff <= rel_tag_in;
      if (load_out) begin
         rsp_tdata_ff <= RSP_W'({ot_cnt_in, wr_cnt_in, rd_cnt_in, res_in.dropped,
                                 rel_tag_in, res_in.rel_valid, res_in.accepted});
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

@@ bench/read_return_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// read_return_checker
// Watches the request, result and register ports of the in-order read
// return buffer, keeps its own copy of the order queue, merge store and
// counters, and compares every result with the oldest expected one.
// ----------------------------------------------------------------------------
module read_return_checker #(
   parameter int REQ_W = ((irb_pkg::TAG_WIDTH_DEF + 3 + 7) / 8) * 8,
   parameter int RSP_W = ((irb_pkg::TAG_WIDTH_DEF + 99 + 7) / 8) * 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   input  logic                        req_tready,
   input  logic [REQ_W-1:0]            req_tdata,
   input  logic [1:0]                  req_tuser,
   input  logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [RSP_W-1:0]            rsp_tdata,
   input  logic                        csr_wr_en,
   input  logic [irb_pkg::LIMIT_W-1:0] csr_wr_data,
   output int                          error_count,
   output int                          pending_results
);
   import irb_pkg::*;

   // highest bit first, matching the rsp_tdata layout
   typedef struct packed {
      logic [31:0] other_total;
      logic [31:0] write_total;
      logic [31:0] read_total;
      logic        dropped;
      logic [31:0] released_tag;
      logic        released;
      logic        accepted;
   } buffer_return_type;

   logic [31:0]        order_tags [16];
   logic [3:0]         order_head;
   logic [4:0]         order_count;
   logic [31:0]        merge_tags [16];
   logic [15:0]        merge_valid;
   logic [31:0]        reads_taken;
   logic [31:0]        writes_taken;
   logic [31:0]        others_taken;
   logic [LIMIT_W-1:0] read_limit;
   // expected results, oldest at exp_first
   buffer_return_type  expected_returns [16];
   int                 exp_first;
   int                 exp_count;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: %s mismatch, got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Apply one request to the local buffer state and work out its result.
   task automatic advance_buffer(input logic [1:0] func, input logic [1:0] kind,
                                 input logic [31:0] tag, input logic chan_ok,
                                 output buffer_return_type res);
      int          cap;
      int          best;
      logic        found;
      logic        placed;
      logic [3:0]  slot;
      res    = '0;
      cap    = (read_limit > 16) ? 16 : int'(read_limit);
      found  = 1'b0;
      placed = 1'b0;
      best   = 0;
      case (func)
         FUNC_ISSUE: begin
            if (int'(order_count) < cap && chan_ok) begin
               res.accepted = 1'b1;
               if (kind == KIND_READ) begin
                  reads_taken++;
                  slot = order_head + order_count[3:0];
                  order_tags[slot] = tag;
                  order_count++;
               end else if (kind == KIND_WRITE) begin
                  writes_taken++;
               end else begin
                  others_taken++;
               end
            end
         end
         FUNC_COMPL: begin
            for (int i = 0; i < 16; i++) begin
               if (!placed && !merge_valid[i]) begin
                  merge_valid[i] = 1'b1;
                  merge_tags[i]  = tag;
                  placed         = 1'b1;
               end
            end
            res.dropped = !placed;
         end
         FUNC_TICK: begin
            // strict compare keeps the lowest slot among equal tags
            for (int i = 0; i < 16; i++) begin
               if (merge_valid[i] && (!found || merge_tags[i] < merge_tags[best])) begin
                  best  = i;
                  found = 1'b1;
               end
            end
            if (found && order_count != 0 && merge_tags[best] == order_tags[order_head]) begin
               merge_valid[best] = 1'b0;
               res.released      = 1'b1;
               res.released_tag  = order_tags[order_head];
               order_head++;
               order_count--;
            end
         end
         default: ;
      endcase
      res.read_total  = reads_taken;
      res.write_total = writes_taken;
      res.other_total = others_taken;
   endtask

   always @(posedge clock) begin : watch_ports
      buffer_return_type got;
      buffer_return_type want;
      if (reset) begin
         order_head   = '0;
         order_count  = '0;
         merge_valid  = '0;
         reads_taken  = '0;
         writes_taken = '0;
         others_taken = '0;
         read_limit   = LIMIT_RESET;
         error_count  = 0;
         exp_first    = 0;
         exp_count    = 0;
      end else begin
         if (csr_wr_en)
            read_limit = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(buffer_return_type)-1:0];
            if (exp_count == 0) begin
               report_mismatch("unexpected result, tag", got.released_tag, '0);
            end else begin
               want      = expected_returns[exp_first];
               exp_first = (exp_first + 1) % 16;
               exp_count--;
               if (got.accepted !== want.accepted)
                  report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
               if (got.released !== want.released)
                  report_mismatch("released_valid", 32'(got.released),
                                  32'(want.released));
               if (got.released_tag !== want.released_tag)
                  report_mismatch("released_tag", got.released_tag, want.released_tag);
               if (got.dropped !== want.dropped)
                  report_mismatch("completion_dropped", 32'(got.dropped),
                                  32'(want.dropped));
               if (got.read_total !== want.read_total)
                  report_mismatch("read_total", got.read_total, want.read_total);
               if (got.write_total !== want.write_total)
                  report_mismatch("write_total", got.write_total, want.write_total);
               if (got.other_total !== want.other_total)
                  report_mismatch("other_total", got.other_total, want.other_total);
            end
         end
         if (req_tvalid && req_tready) begin
            advance_buffer(req_tuser, req_tdata[1:0], req_tdata[33:2], req_tdata[34], want);
            if (exp_count == 16) begin
               report_mismatch("result backlog, count", 32'(exp_count), 32'd15);
            end else begin
               expected_returns[(exp_first + exp_count) % 16] = want;
               exp_count++;
            end
         end
      end
      pending_results = exp_count;
   end

endmodule

@@ bench/in_order_read_return_buffer_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// in_order_read_return_buffer_unit_tb
// Drives issue, completion and tick requests into the read return buffer:
// a short directed opening, then phases at several read limits made of
// well-formed read batches (reads issued in stamp order, completions in
// shuffled order, ticks to drain) mixed with noise, plus merge store
// overflow runs. Checking is done by read_return_checker.
// ----------------------------------------------------------------------------
module in_order_read_return_buffer_unit_tb;
   import irb_pkg::*;

   localparam int REQ_W = ((TAG_WIDTH_DEF + 3 + 7) / 8) * 8;
   localparam int RSP_W = ((TAG_WIDTH_DEF + 99 + 7) / 8) * 8;
   localparam int ITEM_TARGET = 1900;

   localparam logic [1:0] FUNC_NOP   = 2'd3;
   localparam logic [1:0] KIND_OTHER = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   logic               clock;
   logic               reset       = 1'b1;
   logic               req_tvalid  = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata   = '0;
   logic [1:0]         req_tuser   = '0;
   logic               rsp_tvalid;
   logic               rsp_tready  = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_wr_en   = 1'b0;
   logic [LIMIT_W-1:0] csr_wr_data = '0;

   int error_count;
   int pending_results;
   bit gaps_on    = 1'b1;
   int items_sent = 0;
   int read_cap   = 16;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   in_order_read_return_buffer_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   read_return_checker return_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .error_count     (error_count),
      .pending_results (pending_results)
   );

   always @(negedge clock) begin
      rsp_tready <= gaps_on ? ($urandom_range(99) >= 22) : 1'b1;
   end

   // tdata: req_kind [1:0], tag [33:2], channel_accepted [34]; tuser: func
   task automatic send_request(input logic [1:0] func, input logic [1:0] kind,
                               input logic [31:0] tag, input logic chan_ok);
      while (gaps_on && $urandom_range(99) < 22) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {5'b0, chan_ok, tag, kind};
      do @(posedge clock); while (!req_tready);
      if (func != FUNC_NOP)
         items_sent++;
   endtask

   // Requests that never disturb the read order: no completions, no taken reads.
   task automatic send_noise();
      logic [31:0] junk;
      junk = $urandom;
      case ($urandom_range(4))
         0: send_request(FUNC_ISSUE, KIND_WRITE, junk, 1'($urandom_range(1)));
         1: send_request(FUNC_ISSUE, ($urandom_range(1) != 0) ? KIND_OTHER : KIND_SPARE,
                         junk, 1'($urandom_range(1)));
         2: send_request(FUNC_ISSUE, KIND_READ, junk, 1'b0);
         3: send_request(FUNC_TICK, 2'($urandom_range(3)), junk, 1'($urandom_range(1)));
         default: send_request(FUNC_NOP, 2'($urandom_range(3)), junk,
                               1'($urandom_range(1)));
      endcase
   endtask

   // Wait for the buffer to go idle, then write the read limit.
   task automatic write_read_limit(input logic [LIMIT_W-1:0] limit);
      do begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end while (pending_results != 0);
      // a releasing tick may still be sweeping the merge store
      repeat (30) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      read_cap = (limit > 16) ? 16 : int'(limit);
   endtask

   // Issue a run of reads in stamp order, complete them shuffled, then drain.
   task automatic read_batch();
      int          n;
      int          pick;
      int          slot_order [16];
      logic [31:0] stamps [16];
      logic [31:0] stamp;
      n = ($urandom_range(3) == 0) ? read_cap : $urandom_range(read_cap, 1);
      stamp = $urandom_range(32'hFFFF_EFFF);
      for (int i = 0; i < n; i++) begin
         stamp = stamp + (($urandom_range(3) == 0) ? 0 : $urandom_range(255, 1));
         stamps[i] = stamp;
         slot_order[i] = i;
      end
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(2) == 0)
            send_noise();
         send_request(FUNC_ISSUE, KIND_READ, stamps[i], 1'b1);
      end
      // queue at the limit: every kind must now be refused
      if (n == read_cap)
         repeat ($urandom_range(2, 1))
            send_request(FUNC_ISSUE, 2'($urandom_range(3)), $urandom, 1'b1);
      for (int i = n - 1; i > 0; i--) begin
         pick = $urandom_range(i);
         {slot_order[i], slot_order[pick]} = {slot_order[pick], slot_order[i]};
      end
      for (int i = 0; i < n; i++) begin
         send_request(FUNC_COMPL, 2'($urandom_range(3)), stamps[slot_order[i]],
                      1'($urandom_range(1)));
         if ($urandom_range(1))
            send_request(FUNC_TICK, 2'($urandom_range(3)), $urandom,
                         1'($urandom_range(1)));
         if ($urandom_range(4) == 0)
            send_noise();
      end
      repeat (n) send_request(FUNC_TICK, 2'($urandom_range(3)), $urandom,
                              1'($urandom_range(1)));
   endtask

   // Overfill the merge store with no reads queued, then retire what it kept.
   task automatic overflow_merge_store();
      logic [31:0] first;
      int          extra;
      int          issued;
      int          chunk;
      first = $urandom_range(32'hFFFF_FFE0);
      extra = $urandom_range(3, 1);
      for (int i = 0; i < 16 + extra; i++) begin
         send_request(FUNC_COMPL, KIND_READ, first + i, 1'b1);
         if ($urandom_range(3) == 0)
            send_request(FUNC_TICK, KIND_READ, first, 1'b1);
      end
      issued = 0;
      while (issued < 16) begin
         chunk = (16 - issued < read_cap) ? 16 - issued : read_cap;
         for (int j = 0; j < chunk; j++)
            send_request(FUNC_ISSUE, KIND_READ, first + issued + j, 1'b1);
         repeat (chunk) send_request(FUNC_TICK, KIND_READ, '0, 1'b0);
         issued += chunk;
      end
   endtask

   initial begin
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int               phase;
      logic [LIMIT_W-1:0] limit;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed opening at the reset limit
      send_request(FUNC_TICK, KIND_READ, '0, 1'b0);
      send_request(FUNC_NOP, KIND_SPARE, '1, 1'b1);
      send_request(FUNC_ISSUE, KIND_READ, '0, 1'b1);
      send_request(FUNC_ISSUE, KIND_READ, '1, 1'b0);
      send_request(FUNC_ISSUE, KIND_WRITE, 32'h5555_5555, 1'b1);
      send_request(FUNC_ISSUE, KIND_OTHER, 32'hAAAA_AAAA, 1'b1);
      send_request(FUNC_ISSUE, KIND_SPARE, '1, 1'b1);
      send_request(FUNC_ISSUE, KIND_WRITE, '1, 1'b0);
      send_request(FUNC_COMPL, KIND_SPARE, '0, 1'b1);
      send_request(FUNC_TICK, KIND_READ, '0, 1'b0);
      // two reads with the same stamp
      send_request(FUNC_ISSUE, KIND_READ, '1, 1'b1);
      send_request(FUNC_ISSUE, KIND_READ, '1, 1'b1);
      send_request(FUNC_COMPL, KIND_READ, '1, 1'b0);
      send_request(FUNC_COMPL, KIND_READ, '1, 1'b0);
      send_request(FUNC_TICK, KIND_SPARE, '1, 1'b1);
      send_request(FUNC_TICK, KIND_READ, '0, 1'b0);
      send_request(FUNC_TICK, KIND_READ, '0, 1'b0);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         case (phase)
            0: limit = 5'd0;
            1: limit = 5'd31;
            2: limit = 5'd1;
            3: limit = 5'd16;
            4: limit = 5'd17;
            default: limit = LIMIT_W'($urandom_range(31));
         endcase
         write_read_limit(limit);
         gaps_on = (phase != 3);
         if (read_cap == 0) begin
            repeat (40) begin
               if ($urandom_range(1))
                  send_request(FUNC_ISSUE, 2'($urandom_range(3)), $urandom,
                               1'($urandom_range(1)));
               else
                  send_noise();
            end
         end else begin
            repeat ((phase == 3) ? 12 : 5) read_batch();
            if (phase == 1 || $urandom_range(2) == 0)
               overflow_merge_store();
         end
         phase++;
      end

      gaps_on = 1'b1;
      do begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end while (pending_results != 0);
      repeat (40) @(negedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
